// ===== hdl/dfwd_pkg.sv =====
// Package of shared types and constants for the deauthentication flood detector.
`default_nettype none

package dfwd_pkg;

	localparam int TIME_W     = 32;
	localparam int MAC_W      = 48;
	localparam int REASON_W   = 16;
	localparam int COUNT_W    = 9;
	localparam int THRESH_W   = 9;
	localparam int WIN_S_W    = 16;
	localparam int WIN_MS_W   = 26;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int MS_PER_S   = 1000;

	localparam logic [THRESH_W-1:0]  THRESH_RESET = 9'd10;
	localparam logic [WIN_MS_W-1:0]  WIN_MS_RESET = 26'd10000;
	localparam logic [COUNT_W-1:0]   COUNT_MAX    = 9'h1FF;

	localparam logic [CFG_IDX_W-1:0] CFG_FLOOD_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                is_event;
		logic [REASON_W-1:0] reason;
		logic [MAC_W-1:0]    source;
		logic [MAC_W-1:0]    target;
		logic [MAC_W-1:0]    bssid;
		logic [TIME_W-1:0]   now_ms;
	} frame_t;

	typedef struct packed {
		logic                flood_flag;
		logic [COUNT_W-1:0]  window_count;
		logic [REASON_W-1:0] reason;
		logic [MAC_W-1:0]    source;
		logic [MAC_W-1:0]    target;
		logic [MAC_W-1:0]    bssid;
		logic [TIME_W-1:0]   now_ms;
	} alert_t;

	// Sequencer strobes that drive the datapath.
	typedef struct packed {
		logic in_ready;
		logic do_write;
		logic do_cmp;
		logic do_done;
	} seq_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dfwd_if.sv =====
// Valid/ready channel interfaces for frame summaries and alert results.
`default_nettype none

interface dfwd_frame_if;
	import dfwd_pkg::*;

	logic                valid;
	logic                ready;
	logic                frame_is_deauth;
	logic                frame_is_disassoc;
	logic [REASON_W-1:0] frame_reason;
	logic [MAC_W-1:0]    transmitter_mac;
	logic [MAC_W-1:0]    receiver_mac;
	logic [MAC_W-1:0]    bssid_in;
	logic [TIME_W-1:0]   now_ms;

	modport source (
		output valid, frame_is_deauth, frame_is_disassoc, frame_reason,
		       transmitter_mac, receiver_mac, bssid_in, now_ms,
		input  ready
	);
	modport sink (
		input  valid, frame_is_deauth, frame_is_disassoc, frame_reason,
		       transmitter_mac, receiver_mac, bssid_in, now_ms,
		output ready
	);
endinterface

interface dfwd_alert_if;
	import dfwd_pkg::*;

	logic                valid;
	logic                ready;
	logic                flood_flag;
	logic [COUNT_W-1:0]  window_count;
	logic [REASON_W-1:0] alert_reason;
	logic [MAC_W-1:0]    alert_source;
	logic [MAC_W-1:0]    alert_target;
	logic [MAC_W-1:0]    alert_bssid;
	logic [TIME_W-1:0]   alert_time;

	modport source (
		output valid, flood_flag, window_count, alert_reason, alert_source,
		       alert_target, alert_bssid, alert_time,
		input  ready
	);
	modport sink (
		input  valid, flood_flag, window_count, alert_reason, alert_source,
		       alert_target, alert_bssid, alert_time,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/dfwd_ring.sv =====
// Ring memory of event times: one write port and one registered read port.
`default_nettype none

module dfwd_ring #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [IW-1:0]              waddr,
	input  wire logic [dfwd_pkg::TIME_W-1:0] wdata,
	input  wire logic [IW-1:0]              raddr,
	output logic      [dfwd_pkg::TIME_W-1:0] rdata_q
);
	import dfwd_pkg::*;

	logic [TIME_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/dfwd_age_cmp.sv =====
// Shared age unit: wrap-aware age of one ring entry against the window.
`default_nettype none

module dfwd_age_cmp (
	input  wire logic [dfwd_pkg::TIME_W-1:0]   now_ms,
	input  wire logic [dfwd_pkg::TIME_W-1:0]   entry_ms,
	input  wire logic [dfwd_pkg::WIN_MS_W-1:0] window_ms,
	output logic                               expired
);
	import dfwd_pkg::*;

	logic [TIME_W-1:0] age;

	// Modulo 2^32 difference, so a wrapped timestamp still gives its true age.
	assign age     = now_ms - entry_ms;
	assign expired = age > TIME_W'(window_ms);

endmodule

`default_nettype wire

// ===== hdl/deauth_flood_window_detector_core.sv =====
// Top level of the deauthentication flood detector with its sequencer.
// Sequence: a non-event frame goes from IDLE to DONE and then to the output register;
// an event frame goes through WRITE, then READ and CMP for each entry aged, then DONE.
// A new frame is taken only in IDLE, and DONE waits for a free output register; the pace
// is set by the single ring read port and the shared age compare, one entry per pass.
// Reset: arst_n clears the sequencer, ring pointers and result valid; registers
// return to threshold 10 and a 10 s window. Ring contents are not cleared.
`default_nettype none

module deauth_flood_window_detector_core #(
	parameter int HISTORY_DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dfwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dfwd_pkg::CFG_DATA_W-1:0] cfg_data,
	dfwd_frame_if.sink                            frame,
	dfwd_alert_if.source                          alert
);
	import dfwd_pkg::*;

	// Index width for ring positions and count width able to hold the depth itself.
	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [CW-1:0] DEPTH_C    = CW'(HISTORY_DEPTH);
	localparam logic [CW:0]   DEPTH_SUM  = (CW + 1)'(HISTORY_DEPTH);
	localparam logic [IW-1:0] LAST_INDEX = IW'(HISTORY_DEPTH - 1);

	// Configuration. The window is kept in milliseconds so that the age
	// compare never needs the multiply; the multiply by 1000 happens on write.
	logic [THRESH_W-1:0] thresh_q;
	logic [WIN_MS_W-1:0] window_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= THRESH_RESET;
			window_ms_q <= WIN_MS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLOOD_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				CFG_WINDOW_SECONDS: begin
					window_ms_q <= WIN_MS_W'(cfg_data[WIN_S_W-1:0])
					               * WIN_MS_W'(MS_PER_S);
				end
				default: ;
			endcase
		end
	end

	function automatic logic [IW-1:0] next_index(input logic [IW-1:0] idx);
		next_index = (idx == LAST_INDEX) ? '0 : idx + 1'b1;
	endfunction

	// Sequencer state and ring pointers.
	state_t          state_q, state_d;
	seq_ctrl_t       ctrl;
	frame_t          item_q;
	logic [IW-1:0]   oldest_q;
	logic [CW-1:0]   kept_q;
	alert_t          out_q;
	logic            out_valid_q;
	logic            in_beat;
	logic            out_free;
	logic            expired;
	logic [TIME_W-1:0] rdata_q;

	assign in_beat  = frame.valid && frame.ready;
	assign out_free = !out_valid_q || alert.ready;

	// Next-state logic. A popped entry loops back through READ for the next
	// oldest one; the newest entry has age zero, so the loop always ends.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_d = (frame.frame_is_deauth || frame.frame_is_disassoc)
					          ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE: state_d = ST_READ;
			ST_READ:  state_d = ST_CMP;
			ST_CMP: begin
				state_d = (expired && kept_q > CW'(1)) ? ST_READ : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output strobes of the sequencer.
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_WRITE: ctrl.do_write = 1'b1;
			ST_READ:  ;
			ST_CMP:   ctrl.do_cmp   = 1'b1;
			ST_DONE:  ctrl.do_done  = out_free;
			default:  ;
		endcase
	end

	assign frame.ready = ctrl.in_ready;

	// Write position: when the ring is full the oldest entry is dropped
	// first, then the new time goes just past the newest kept entry.
	logic            full;
	logic [IW-1:0]   oldest_eff;
	logic [CW-1:0]   kept_eff;
	logic [CW:0]     pos_sum;
	logic [IW-1:0]   wr_pos;

	assign full       = (kept_q == DEPTH_C);
	assign oldest_eff = full ? next_index(oldest_q) : oldest_q;
	assign kept_eff   = full ? DEPTH_C - 1'b1 : kept_q;
	assign pos_sum    = (CW + 1)'(oldest_eff) + (CW + 1)'(kept_eff);
	assign wr_pos     = (pos_sum >= DEPTH_SUM) ? IW'(pos_sum - DEPTH_SUM) : IW'(pos_sum);

	dfwd_ring #(
		.DEPTH (HISTORY_DEPTH),
		.IW    (IW)
	) u_ring (
		.clk     (clk),
		.we      (ctrl.do_write),
		.waddr   (wr_pos),
		.wdata   (item_q.now_ms),
		.raddr   (oldest_q),
		.rdata_q (rdata_q)
	);

	dfwd_age_cmp u_age (
		.now_ms    (item_q.now_ms),
		.entry_ms  (rdata_q),
		.window_ms (window_ms_q),
		.expired   (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			kept_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.do_write) begin
				oldest_q <= oldest_eff;
				kept_q   <= kept_eff + 1'b1;
			end else if (ctrl.do_cmp && expired && kept_q != '0) begin
				oldest_q <= next_index(oldest_q);
				kept_q   <= kept_q - 1'b1;
			end
		end
	end

	// The accepted beat is held for the whole run of the sequencer.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_q.is_event <= frame.frame_is_deauth || frame.frame_is_disassoc;
			item_q.reason   <= frame.frame_reason;
			item_q.source   <= frame.transmitter_mac;
			item_q.target   <= frame.receiver_mac;
			item_q.bssid    <= frame.bssid_in;
			item_q.now_ms   <= frame.now_ms;
		end
	end

	// Result: the count saturates to the field, the flag compares the true count.
	logic [KW-1:0]      kept_ext;
	logic [COUNT_W-1:0] count_sat;
	logic               flood;

	assign kept_ext  = KW'(kept_q);
	assign count_sat = (kept_ext > KW'(COUNT_MAX)) ? COUNT_MAX : kept_ext[COUNT_W-1:0];
	assign flood     = kept_ext >= KW'(thresh_q);

	// Output register: a finished result waits here while IDLE takes the next beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.do_done) begin
			out_valid_q <= 1'b1;
		end else if (alert.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.do_done) begin
			out_q.flood_flag   <= item_q.is_event && flood;
			out_q.window_count <= item_q.is_event ? count_sat : '0;
			out_q.reason       <= item_q.reason;
			out_q.source       <= item_q.source;
			out_q.target       <= item_q.target;
			out_q.bssid        <= item_q.bssid;
			out_q.now_ms       <= item_q.now_ms;
		end
	end

	assign alert.valid        = out_valid_q;
	assign alert.flood_flag   = out_q.flood_flag;
	assign alert.window_count = out_q.window_count;
	assign alert.alert_reason = out_q.reason;
	assign alert.alert_source = out_q.source;
	assign alert.alert_target = out_q.target;
	assign alert.alert_bssid  = out_q.bssid;
	assign alert.alert_time   = out_q.now_ms;

	// The kept count never exceeds the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n) kept_q <= DEPTH_C)
		else $error("kept count beyond ring depth");

	// While entries are being aged there is always at least the newest one kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP || state_q == ST_READ) |-> kept_q != '0)
		else $error("pruning with an empty ring");

	// A frame that is no event goes straight to the result stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !frame.frame_is_deauth && !frame.frame_is_disassoc)
		|=> state_q == ST_DONE)
		else $error("non-event frame entered the ring path");

	// Ring pointers move only under the write or compare strobes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_READ)
		|=> $stable(kept_q))
		else $error("kept count changed outside write or compare");

endmodule

`default_nettype wire
